### hdl/srx_esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_esc_pkg
// Shared constants, event codes and the escape letter decoder for the serial
// receive path.
// ----------------------------------------------------------------------------
package srx_esc_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 256;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int THRESH_W    = 9;
   localparam int RUN_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int EVENT_W     = 3;
   localparam int FILL_W      = 8;
   localparam int DROP_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CTS_ASSERT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CTS_RELEASE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BANNER_RUN  = 2'd2;

   localparam logic [THRESH_W-1:0] CTS_ASSERT_RESET  = 9'd17;
   localparam logic [THRESH_W-1:0] CTS_RELEASE_RESET = 9'd34;
   localparam logic [RUN_W-1:0]    BANNER_RUN_RESET  = 8'd80;

   localparam logic [BYTE_W-1:0] BANNER_BYTE_A = 8'h86;
   localparam logic [BYTE_W-1:0] BANNER_BYTE_B = 8'h98;
   localparam logic [BYTE_W-1:0] CHAR_BANG     = 8'h21;
   localparam logic [BYTE_W-1:0] CHAR_DOT      = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_CLEAR    = 8'h43;

   localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;

   typedef logic [EVENT_W-1:0] event_type;

   localparam event_type EV_NONE     = 3'd0;
   localparam event_type EV_STORED   = 3'd1;
   localparam event_type EV_FLUSH    = 3'd2;
   localparam event_type EV_EXTCMD   = 3'd3;
   localparam event_type EV_UNKNOWN  = 3'd4;
   localparam event_type EV_OVERFLOW = 3'd5;
   localparam event_type EV_ATMODE   = 3'd6;
   localparam event_type EV_CLEARED  = 3'd7;

   localparam logic KIND_RX   = 1'b0;
   localparam logic KIND_READ = 1'b1;

   function automatic logic is_command_letter(input logic [BYTE_W-1:0] c);
      logic hit;
      hit = 1'b0;
      if (c >= 8'h61 && c <= 8'h7A) begin
         hit = 1'b1;
      end
      if (c >= 8'h30 && c <= 8'h39) begin
         hit = 1'b1;
      end
      case (c)
         8'h4D, 8'h48, 8'h4C, 8'h50, 8'h42, 8'h44, 8'h45,
         8'h49, 8'h46, 8'h59, 8'h5A, 8'h52, 8'h56: begin
            hit = 1'b1;
         end
         default: begin
         end
      endcase
      return hit;
   endfunction

endpackage

### hdl/serial_rx_escape_fifo_flow_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_rx_escape_fifo_flow_control
// Receive byte escape decoder with boot banner detection, ring FIFO, drop
// counter and hysteretic clear-to-send control.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// req_     in         req_valid/req_ready  kind, rx_byte, at_mode
// rsp_     out        rsp_valid/rsp_ready  read_data .. overflow_count
// csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// A request is captured in an input register and then finished into the
// response register, so one request is taken every cycle while the response
// is not stalled; the response is valid once it has passed both registers.
// The FIFO head is prefetched from the store each cycle with write bypass.
// Reset clears pointers, counters and flow control; the store is not cleared.
// A stalled response holds the input register, which then stalls req_ready.
// ----------------------------------------------------------------------------
module serial_rx_escape_fifo_flow_control
   import srx_esc_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   input  logic                   req_at_mode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_W-1:0]      rsp_read_data,
   output logic [EVENT_W-1:0]     rsp_event_res,
   output logic [BYTE_W-1:0]      rsp_command_byte,
   output logic                   rsp_banner_detected,
   output logic                   rsp_silence_cancel,
   output logic                   rsp_cts_stop,
   output logic [FILL_W-1:0]      rsp_fill_level,
   output logic [DROP_W-1:0]      rsp_overflow_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PTR_W   = $clog2(FIFO_DEPTH);
   localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
   localparam int CMP_W   = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;
   localparam int FEXT_W  = (CNT_W > FILL_W) ? CNT_W : FILL_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(FIFO_DEPTH);

   logic [BYTE_W-1:0] store [FIFO_DEPTH];

   logic [THRESH_W-1:0] cts_assert_ff;
   logic [THRESH_W-1:0] cts_release_ff;
   logic [RUN_W-1:0]    banner_run_ff;

   logic              in_valid_ff;
   logic              in_kind_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_at_mode_ff;

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic              esc_ff, esc_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic              cts_ff, cts_in;

   logic [BYTE_W-1:0] head_ff;
   logic              byp_ff;
   logic [BYTE_W-1:0] byp_data_ff;
   logic [BYTE_W-1:0] head;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] read_data_ff, read_data_in;
   event_type         event_ff, event_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic              banner_ff, banner_in;
   logic              cancel_ff, cancel_in;
   logic [FILL_W-1:0] fill_out_ff, fill_out_in;

   logic              fire;
   logic              out_free;
   logic              we;
   logic [BYTE_W-1:0] wdata;
   logic [PTR_W-1:0]  wp_next;
   logic              full;
   logic              push_req;
   logic [RUN_W-1:0]  run_tmp;
   logic [CNT_W-1:0]  fill_after;
   logic [CNT_W-1:0]  free_after;
   logic [FEXT_W-1:0] fill_ext;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign csr_ready = 1'b1;
   assign head      = byp_ff ? byp_data_ff : head_ff;
   assign wp_next   = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
   assign full      = (wp_next == rp_ff);

   always_comb begin
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      esc_in       = esc_ff;
      prev_in      = prev_ff;
      run_in       = run_ff;
      drop_in      = drop_ff;
      cts_in       = cts_ff;
      read_data_in = '0;
      event_in     = EV_NONE;
      cmd_in       = '0;
      banner_in    = 1'b0;
      cancel_in    = 1'b0;
      we           = 1'b0;
      wdata        = in_byte_ff;
      push_req     = 1'b0;
      run_tmp      = '0;
      fill_after   = '0;
      free_after   = '0;
      fill_ext     = '0;
      fill_out_in  = '0;

      if (fire) begin
         if (in_kind_ff == KIND_READ) begin
            if (wp_ff != rp_ff) begin
               read_data_in = head;
               rp_in        = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTR_W'(1);
            end
         end else begin
            if ((prev_ff == BANNER_BYTE_A && in_byte_ff == BANNER_BYTE_B) ||
                (prev_ff == BANNER_BYTE_B && in_byte_ff == BANNER_BYTE_A)) begin
               run_tmp = run_ff + RUN_W'(1);
            end
            if (run_tmp >= banner_run_ff) begin
               banner_in = 1'b1;
               run_in    = '0;
            end else begin
               run_in = run_tmp;
            end
            prev_in = in_byte_ff;

            if (in_at_mode_ff) begin
               event_in = EV_ATMODE;
            end else if (in_byte_ff == CHAR_BANG) begin
               cancel_in = 1'b1;
               if (esc_ff) begin
                  event_in = EV_FLUSH;
                  esc_in   = 1'b0;
               end else begin
                  esc_in = 1'b1;
               end
            end else if (esc_ff) begin
               esc_in = 1'b0;
               if (in_byte_ff == CHAR_CLEAR) begin
                  rp_in    = wp_ff;
                  event_in = EV_CLEARED;
               end else if (in_byte_ff == CHAR_DOT) begin
                  push_req = 1'b1;
                  wdata    = CHAR_BANG;
               end else if (is_command_letter(in_byte_ff)) begin
                  event_in = EV_EXTCMD;
                  cmd_in   = in_byte_ff;
               end else begin
                  event_in = EV_UNKNOWN;
               end
            end else begin
               push_req = 1'b1;
            end

            if (push_req) begin
               if (full) begin
                  event_in = EV_OVERFLOW;
                  if (drop_ff != DROP_MAX) begin
                     drop_in = drop_ff + DROP_W'(1);
                  end
               end else begin
                  event_in = EV_STORED;
                  we       = 1'b1;
                  wp_in    = wp_next;
               end
            end
         end

         fill_after = CNT_W'(wp_in) - CNT_W'(rp_in) + ((wp_in < rp_in) ? DEPTH_C : '0);
         free_after = DEPTH_C - fill_after;

         if (in_kind_ff == KIND_READ) begin
            if (CMP_W'(free_after) > CMP_W'(cts_release_ff)) begin
               cts_in = 1'b0;
            end
         end else if (!in_at_mode_ff) begin
            if (CMP_W'(free_after) < CMP_W'(cts_assert_ff)) begin
               cts_in = 1'b1;
            end
         end

         fill_ext    = FEXT_W'(fill_after);
         fill_out_in = fill_ext[FILL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store[wp_ff] <= wdata;
      end
      head_ff     <= store[rp_in];
      byp_ff      <= we && (wp_ff == rp_in);
      byp_data_ff <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cts_assert_ff  <= CTS_ASSERT_RESET;
         cts_release_ff <= CTS_RELEASE_RESET;
         banner_run_ff  <= BANNER_RUN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CTS_ASSERT:  cts_assert_ff  <= csr_data;
            CSR_CTS_RELEASE: cts_release_ff <= csr_data;
            CSR_BANNER_RUN:  banner_run_ff  <= csr_data[RUN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_kind_ff    <= req_kind;
         in_byte_ff    <= req_rx_byte;
         in_at_mode_ff <= req_at_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         esc_ff  <= 1'b0;
         prev_ff <= '0;
         run_ff  <= '0;
         drop_ff <= '0;
         cts_ff  <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         esc_ff  <= esc_in;
         prev_ff <= prev_in;
         run_ff  <= run_in;
         drop_ff <= drop_in;
         cts_ff  <= cts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (fire) begin
         read_data_ff <= read_data_in;
         event_ff     <= event_in;
         cmd_ff       <= cmd_in;
         banner_ff    <= banner_in;
         cancel_ff    <= cancel_in;
         fill_out_ff  <= fill_out_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = read_data_ff;
   assign rsp_event_res       = event_ff;
   assign rsp_command_byte    = cmd_ff;
   assign rsp_banner_detected = banner_ff;
   assign rsp_silence_cancel  = cancel_ff;
   assign rsp_cts_stop        = cts_ff;
   assign rsp_fill_level      = fill_out_ff;
   assign rsp_overflow_count  = drop_ff;

endmodule
